@@ hdl/sarp_pkg.sv @@
// shared types, constants and helpers of the shadow atlas rectangle packer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package sarp_pkg;

	localparam logic [4:0] MAX_FOCUSED = 5'd16;
	localparam logic [4:0] MAX_COLUMNS = 5'd16;
	localparam logic [14:0] MIN_SIDE = 15'd256;
	localparam logic [14:0] MAX_DIM_RST = 15'd16384;
	// register index, taken from paddr[2]
	localparam logic REG_MAX_DIM = 1'b0;

	// layout handed from the search to the emitter
	typedef struct packed {
		logic [14:0] r;
		logic [14:0] h;
		logic [15:0] header;
		logic [14:0] aw;
		logic [14:0] ah;
		logic [4:0]  n;
		logic [4:0]  first;
		logic [4:0]  other;
	} desc_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GEN,
		S_DRAIN,
		S_PUSH
	} srch_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_HDR,
		E_MAP
	} emit_state_t;

	// smallest p with p*den >= num, for num up to 16
	function automatic logic [4:0] ceil_div(input logic [4:0] num, input logic [3:0] den);
		logic [4:0] res;
		logic [8:0] prod;
		res = MAX_FOCUSED;
		prod = 9'd0;
		for (int p = 16; p >= 0; p--) begin
			prod = 9'(p) * {5'b0, den};
			if (prod >= {4'b0, num}) begin
				res = 5'(p);
			end
		end
		return res;
	endfunction

endpackage

@@ hdl/sarp_search.sv @@
// front end: accepts requests and searches the best atlas layout
// depends on sarp_pkg
`timescale 1ns / 1ps
module sarp_search import sarp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [14:0] max_dim,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [14:0] base_resolution,
	input  logic [4:0]  wanted_maps,
	output logic        desc_valid,
	input  logic        desc_ready,
	output desc_t       desc
);

	srch_state_t state_q, state_d;

	logic [14:0] r_q;
	logic [15:0] hdr_q;
	logic [4:0]  n_q;
	logic [4:0]  cols_q;
	logic [19:0] colr_q;
	logic [4:0]  first_q;
	logic [19:0] top_q;

	logic        v_s1, skip_s1;
	logic [14:0] colr_s1;
	logic [4:0]  first_s1, per_s1;
	logic [19:0] top_s1, perr_s1;

	logic        v_s2;
	logic [14:0] colr_s2, h_s2;
	logic [4:0]  first_s2, per_s2;
	logic [29:0] area_s2;

	logic        best_v_q;
	logic [29:0] best_area_q;
	logic [14:0] best_h_q, best_colr_q;
	logic [4:0]  best_first_q, best_per_q;

	logic [14:0] r_in;
	logic [15:0] hdr_in;
	logic [4:0]  n_in;
	logic [19:0] max20;
	logic        gen_done, cand, adv_first, last_cand, pipe_empty, accept, restart;
	logic [19:0] top_nx;
	logic [4:0]  rest;
	logic [3:0]  den;
	logic [4:0]  per_c;
	logic [19:0] h_c;
	logic        ok_c, better;

	// request decode
	always_comb begin
		r_in = (base_resolution > MIN_SIDE) ? base_resolution : MIN_SIDE;
		hdr_in = {1'b0, r_in} + {2'b0, r_in[14:1]};
		n_in = (wanted_maps > MAX_FOCUSED) ? MAX_FOCUSED : wanted_maps;
		max20 = {5'b0, max_dim};
	end

	// candidate generator
	always_comb begin
		gen_done = colr_q > max20;
		cand = (state_q == S_GEN) && !gen_done;
		top_nx = top_q + {5'b0, r_q};
		adv_first = (first_q < n_q) && (top_nx <= max20);
		last_cand = !adv_first && (cols_q == MAX_COLUMNS);
		pipe_empty = !v_s1 && !v_s2;
		accept = in_valid && in_ready;
		restart = (state_q == S_DRAIN) && pipe_empty && !best_v_q && (n_q != 5'd0);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		desc_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = S_GEN;
			end
			S_GEN: begin
				if (gen_done || last_cand) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (pipe_empty) state_d = restart ? S_GEN : S_PUSH;
			end
			S_PUSH: begin
				desc_valid = 1'b1;
				if (desc_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// generator registers
	always_ff @(posedge clk) begin
		if (accept || restart) begin
			if (accept) begin
				r_q <= r_in;
				hdr_q <= hdr_in;
				n_q <= n_in;
				colr_q <= {5'b0, r_in};
				top_q <= {4'b0, hdr_in};
			end else begin
				n_q <= n_q - 5'd1;
				colr_q <= {5'b0, r_q};
				top_q <= {4'b0, hdr_q};
			end
			cols_q <= 5'd1;
			first_q <= 5'd0;
		end else if (cand) begin
			if (adv_first) begin
				first_q <= first_q + 5'd1;
				top_q <= top_nx;
			end else begin
				cols_q <= cols_q + 5'd1;
				colr_q <= colr_q + {5'b0, r_q};
				first_q <= 5'd0;
				top_q <= {4'b0, hdr_q};
			end
		end
	end

	// stage 1: maps per other column and their height
	always_comb begin
		rest = n_q - first_q;
		den = 4'(cols_q - 5'd1);
		per_c = (cols_q == 5'd1) ? 5'd0 : ceil_div(rest, den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			best_v_q <= 1'b0;
		end else begin
			v_s1 <= cand;
			v_s2 <= v_s1 && ok_c;
			if (accept) best_v_q <= 1'b0;
			else if (better) best_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		skip_s1 <= (cols_q == 5'd1) && (rest != 5'd0);
		colr_s1 <= colr_q[14:0];
		first_s1 <= first_q;
		top_s1 <= top_q;
		per_s1 <= per_c;
		perr_s1 <= per_c * r_q;
	end

	// stage 2: candidate height, bounds and area
	always_comb begin
		h_c = (top_s1 > perr_s1) ? top_s1 : perr_s1;
		ok_c = !skip_s1 && (perr_s1 <= max20) && (h_c <= max20);
	end

	always_ff @(posedge clk) begin
		colr_s2 <= colr_s1;
		first_s2 <= first_s1;
		per_s2 <= per_s1;
		h_s2 <= h_c[14:0];
		area_s2 <= colr_s1 * h_c[14:0];
	end

	// stage 3: keep the best candidate
	always_comb begin
		better = v_s2 && (!best_v_q || (area_s2 < best_area_q) ||
			((area_s2 == best_area_q) && (h_s2 < best_h_q)));
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_area_q <= area_s2;
			best_h_q <= h_s2;
			best_colr_q <= colr_s2;
			best_first_q <= first_s2;
			best_per_q <= per_s2;
		end
	end

	// layout descriptor, clipped header when nothing fits
	always_comb begin
		desc.r = r_q;
		desc.h = r_q >> 1;
		desc.header = hdr_q;
		if (best_v_q) begin
			desc.aw = best_colr_q;
			desc.ah = best_h_q;
			desc.n = n_q;
			desc.first = best_first_q;
			desc.other = best_per_q;
		end else begin
			desc.aw = (max_dim < r_q) ? max_dim : r_q;
			desc.ah = ({1'b0, max_dim} < hdr_q) ? max_dim : hdr_q[14:0];
			desc.n = 5'd0;
			desc.first = 5'd0;
			desc.other = 5'd0;
		end
	end

endmodule

@@ hdl/sarp_fifo.sv @@
// two-entry queue of layout descriptors between search and emitter
// depends on sarp_pkg
`timescale 1ns / 1ps
module sarp_fifo import sarp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  desc_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output desc_t rd_data
);

	desc_t       mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	always_comb begin
		wr_ready = cnt_q != 2'd2;
		rd_valid = cnt_q != 2'd0;
		push = wr_valid && wr_ready;
		pop = rd_valid && rd_ready;
		rd_data = mem_q[rp_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

@@ hdl/sarp_emit.sv @@
// back end: walks a layout descriptor and emits its rectangles
// depends on sarp_pkg
`timescale 1ns / 1ps
module sarp_emit import sarp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        desc_valid,
	output logic        desc_ready,
	input  desc_t       desc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        rect_kind,
	output logic [3:0]  rect_index,
	output logic [14:0] rect_x,
	output logic [14:0] rect_y,
	output logic [14:0] rect_w,
	output logic [14:0] rect_h,
	output logic [14:0] atlas_width,
	output logic [14:0] atlas_height,
	output logic [4:0]  maps_placed,
	output logic        last_rect
);

	emit_state_t state_q, state_d;
	desc_t       d_q;
	logic [1:0]  hidx_q;
	logic [4:0]  placed_q, col_q, row_q;
	logic [19:0] x_q, y_q;
	logic        ovalid_q;
	logic        load, take, done_map;

	always_comb begin
		load = ovalid_q ? out_ready : 1'b1;
		take = desc_valid && desc_ready;
		done_map = (placed_q + 5'd1) == d_q.n;
		out_valid = ovalid_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		desc_ready = 1'b0;
		unique case (state_q)
			E_IDLE: begin
				desc_ready = 1'b1;
				if (desc_valid) state_d = E_HDR;
			end
			E_HDR: begin
				if (load && hidx_q == 2'd2) state_d = (d_q.n == 5'd0) ? E_IDLE : E_MAP;
			end
			E_MAP: begin
				if (load && done_map) state_d = E_IDLE;
			end
			default: state_d = E_IDLE;
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= (state_q == E_HDR) || (state_q == E_MAP);
		end
	end

	// walk counters and output payload
	always_ff @(posedge clk) begin
		if (take) begin
			d_q <= desc;
			hidx_q <= 2'd0;
			placed_q <= 5'd0;
			row_q <= 5'd0;
			y_q <= 20'd0;
			if (desc.first == 5'd0) begin
				col_q <= 5'd1;
				x_q <= {5'b0, desc.r};
			end else begin
				col_q <= 5'd0;
				x_q <= 20'd0;
				y_q <= {4'b0, desc.header};
			end
		end else if (load && state_q == E_HDR) begin
			hidx_q <= hidx_q + 2'd1;
			rect_kind <= 1'b0;
			rect_index <= {2'b0, hidx_q};
			rect_x <= (hidx_q == 2'd2) ? d_q.h : 15'd0;
			rect_y <= (hidx_q == 2'd0) ? 15'd0 : d_q.r;
			rect_w <= (hidx_q == 2'd0) ? d_q.r : d_q.h;
			rect_h <= (hidx_q == 2'd0) ? d_q.r : d_q.h;
			atlas_width <= d_q.aw;
			atlas_height <= d_q.ah;
			maps_placed <= d_q.n;
			last_rect <= (hidx_q == 2'd2) && (d_q.n == 5'd0);
		end else if (load && state_q == E_MAP) begin
			rect_kind <= 1'b1;
			rect_index <= placed_q[3:0];
			rect_x <= x_q[14:0];
			rect_y <= y_q[14:0];
			rect_w <= d_q.r;
			rect_h <= d_q.r;
			last_rect <= done_map;
			placed_q <= placed_q + 5'd1;
			// step down the column, or over to the next one
			if (col_q == 5'd0) begin
				if (row_q + 5'd1 < d_q.first) begin
					row_q <= row_q + 5'd1;
					y_q <= y_q + {5'b0, d_q.r};
				end else begin
					col_q <= 5'd1;
					row_q <= 5'd0;
					x_q <= {5'b0, d_q.r};
					y_q <= 20'd0;
				end
			end else if (row_q + 5'd1 < d_q.other) begin
				row_q <= row_q + 5'd1;
				y_q <= y_q + {5'b0, d_q.r};
			end else begin
				col_q <= col_q + 5'd1;
				row_q <= 5'd0;
				x_q <= x_q + {5'b0, d_q.r};
				y_q <= 20'd0;
			end
		end
	end

endmodule

@@ hdl/shadow_atlas_rect_packer_top.sv @@
// top level of the shadow atlas rectangle packer: register port, search, queue, emitter
// depends on sarp_pkg, sarp_search, sarp_fifo, sarp_emit
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   base_resolution, wanted_maps
// out       output     out_valid / out_ready rect_*, atlas_*, maps_placed, last_rect
// cfg       input      apb write/read        max_dim at byte address 0
//
// a request is searched one candidate a cycle through a three-stage evaluation pipe,
// with up to 16 columns times 17 column-0 counts per count of maps tried; the
// emitter then gives 3 + maps_placed transactions, one a cycle while out_ready is high.
// the search and the emitter are parted by a two-entry descriptor queue, so a
// stalled output does not hold the next search until the queue is full; arst_n
// clears all control state.
`timescale 1ns / 1ps
module shadow_atlas_rect_packer_top import sarp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [14:0] base_resolution,
	input  logic [4:0]  wanted_maps,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        rect_kind,
	output logic [3:0]  rect_index,
	output logic [14:0] rect_x,
	output logic [14:0] rect_y,
	output logic [14:0] rect_w,
	output logic [14:0] rect_h,
	output logic [14:0] atlas_width,
	output logic [14:0] atlas_height,
	output logic [4:0]  maps_placed,
	output logic        last_rect
);

	logic [14:0] max_dim_q;
	logic        q_wv, q_wr, q_rv, q_rr;
	desc_t       q_wd, q_rd;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q <= MAX_DIM_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_DIM)) begin
			max_dim_q <= pwdata[14:0];
		end
	end

	always_comb begin
		prdata = (paddr[2] == REG_MAX_DIM) ? {17'b0, max_dim_q} : 32'd0;
	end

	sarp_search u_search (
		.clk(clk), .arst_n(arst_n), .max_dim(max_dim_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.base_resolution(base_resolution), .wanted_maps(wanted_maps),
		.desc_valid(q_wv), .desc_ready(q_wr), .desc(q_wd)
	);

	sarp_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(q_wv), .wr_ready(q_wr), .wr_data(q_wd),
		.rd_valid(q_rv), .rd_ready(q_rr), .rd_data(q_rd)
	);

	sarp_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.desc_valid(q_rv), .desc_ready(q_rr), .desc(q_rd),
		.out_valid(out_valid), .out_ready(out_ready),
		.rect_kind(rect_kind), .rect_index(rect_index),
		.rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
		.atlas_width(atlas_width), .atlas_height(atlas_height),
		.maps_placed(maps_placed), .last_rect(last_rect)
	);

	// the final map of a layout carries the placed count
	a_last_map: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_rect && rect_kind |-> maps_placed == ({1'b0, rect_index} + 5'd1))
		else $error("last map index does not match placed count");

	// header splits are only indices 0 to 2
	a_hdr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rect_kind |-> rect_index <= 4'd2)
		else $error("header split index out of range");

	// maps only appear in layouts that place some
	a_map_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rect_kind |-> maps_placed != 5'd0)
		else $error("map emitted with no maps placed");

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the shadow atlas rectangle packer
// depends on sarp_pkg and shadow_atlas_rect_packer_top; predicts each layout in software
`timescale 1ns / 1ps
module tb import sarp_pkg::*;;

	typedef struct {
		logic        kind;
		logic [3:0]  idx;
		logic [14:0] x, y, w, h, aw, ah;
		logic [4:0]  placed;
		logic        last;
	} rect_t;

	typedef struct {
		logic [14:0] base;
		logic [4:0]  wanted;
		bit          known;
		logic [14:0] exp_aw, exp_ah;
		logic [4:0]  exp_placed;
	} row_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [14:0] base_resolution;
	logic [4:0]  wanted_maps;
	logic        out_valid, out_ready;
	logic        rect_kind, last_rect;
	logic [3:0]  rect_index;
	logic [14:0] rect_x, rect_y, rect_w, rect_h, atlas_width, atlas_height;
	logic [4:0]  maps_placed;

	rect_t       rect_q[$];
	int          errors;
	int          idle_cycles;
	bit          hold_off;
	logic [14:0] max_dim_m;

	shadow_atlas_rect_packer_top u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// layout search for n maps, smallest area then lowest height then earliest
	function automatic bit fit_layout(input int n, input int r, input int hdr,
			output int cols_o, output int first_o, output int other_o);
		longint best_area, area;
		int cap_first, cap_other, fcap, per, top, ht, best_h;
		cap_first = max_dim_m > hdr ? (max_dim_m - hdr) / r : 0;
		cap_other = max_dim_m / r;
		cols_o = 0; first_o = 0; other_o = 0; best_area = 0; best_h = 0;
		for (int cols = 1; cols <= MAX_COLUMNS; cols++) begin
			fcap = cap_first < n ? cap_first : n;
			if (cols * r > max_dim_m) break;
			for (int f = 0; f <= fcap; f++) begin
				per = 0;
				if (cols == 1) begin
					if (n - f > 0) continue;
				end else begin
					per = (n - f + cols - 2) / (cols - 1);
					if (per > cap_other) continue;
				end
				top = hdr + f * r;
				ht = top > per * r ? top : per * r;
				if (ht > max_dim_m) continue;
				area = longint'(cols * r) * ht;
				if (cols_o == 0 || area < best_area || (area == best_area && ht < best_h)) begin
					best_area = area; best_h = ht;
					cols_o = cols; first_o = f; other_o = per;
				end
			end
		end
		return cols_o != 0;
	endfunction

	function automatic rect_t mk(int kind, int idx, int x, int y, int w, int h,
			int aw, int ah, int placed, int last);
		rect_t t;
		t.kind = 1'(kind); t.idx = 4'(idx); t.x = 15'(x); t.y = 15'(y);
		t.w = 15'(w); t.h = 15'(h); t.aw = 15'(aw); t.ah = 15'(ah);
		t.placed = 5'(placed); t.last = 1'(last);
		return t;
	endfunction

	// append one expected rectangle at the tail of the queue
	task automatic expect_rect(input rect_t t);
		rect_q.insert(rect_q.size(), t);
	endtask

	// queue the expected rectangles of one request
	task automatic predict_layout(input logic [14:0] base, input logic [4:0] wanted);
		int r, hh, hdr, n, cols, f, other, aw, ah, c0, left, t, placed, w;
		bit found;
		r = base > MIN_SIDE ? base : MIN_SIDE;
		hh = r / 2; hdr = r + hh;
		w = wanted > MAX_FOCUSED ? MAX_FOCUSED : wanted;
		found = 0;
		for (n = w; n >= 0; n--) begin
			if (fit_layout(n, r, hdr, cols, f, other)) begin
				found = 1;
				break;
			end
		end
		if (!found) begin
			aw = max_dim_m < r ? max_dim_m : r;
			ah = max_dim_m < hdr ? max_dim_m : hdr;
			expect_rect(mk(0, 0, 0, 0, r, r, aw, ah, 0, 0));
			expect_rect(mk(0, 1, 0, r, hh, hh, aw, ah, 0, 0));
			expect_rect(mk(0, 2, hh, r, hh, hh, aw, ah, 0, 1));
			return;
		end
		aw = cols * r; ah = hdr;
		c0 = f < n ? f : n; left = n - c0;
		if (hdr + c0 * r > ah) ah = hdr + c0 * r;
		if (cols > 1 && left > 0) begin
			t = left < other ? left : other;
			if (t * r > ah) ah = t * r;
		end
		expect_rect(mk(0, 0, 0, 0, r, r, aw, ah, n, 0));
		expect_rect(mk(0, 1, 0, r, hh, hh, aw, ah, n, 0));
		expect_rect(mk(0, 2, hh, r, hh, hh, aw, ah, n, n == 0));
		placed = 0;
		for (int i = 0; i < f && placed < n; i++, placed++)
			expect_rect(mk(1, placed, 0, hdr + i * r, r, r, aw, ah, n, placed + 1 == n));
		for (int c = 1; c < cols && placed < n; c++)
			for (int i = 0; i < other && placed < n; i++, placed++)
				expect_rect(mk(1, placed, c * r, i * r, r, r, aw, ah, n, placed + 1 == n));
	endtask

	// compare each accepted output transaction with the oldest expectation
	always @(posedge clk) begin
		rect_t e;
		if (arst_n && out_valid && out_ready) begin
			if (rect_q.size() == 0) begin
				$error("unexpected transaction");
				errors++;
			end else begin
				e = rect_q.pop_front();
				if (rect_kind !== e.kind) begin $error("rect_kind exp %0d got %0d", e.kind, rect_kind); errors++; end
				if (rect_index !== e.idx) begin $error("rect_index exp %0d got %0d", e.idx, rect_index); errors++; end
				if (rect_x !== e.x) begin $error("rect_x exp %0d got %0d", e.x, rect_x); errors++; end
				if (rect_y !== e.y) begin $error("rect_y exp %0d got %0d", e.y, rect_y); errors++; end
				if (rect_w !== e.w) begin $error("rect_w exp %0d got %0d", e.w, rect_w); errors++; end
				if (rect_h !== e.h) begin $error("rect_h exp %0d got %0d", e.h, rect_h); errors++; end
				if (atlas_width !== e.aw) begin $error("atlas_width exp %0d got %0d", e.aw, atlas_width); errors++; end
				if (atlas_height !== e.ah) begin $error("atlas_height exp %0d got %0d", e.ah, atlas_height); errors++; end
				if (maps_placed !== e.placed) begin $error("maps_placed exp %0d got %0d", e.placed, maps_placed); errors++; end
				if (last_rect !== e.last) begin $error("last_rect exp %0d got %0d", e.last, last_rect); errors++; end
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int mode;
		out_ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (20000) @(posedge clk);
				hold_off = 0;
			end
			mode = ($urandom >> 4) % 4;
			out_ready <= (mode == 0) ? ($urandom_range(0, 3) == 0) :
				(mode == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
		end
	end

	// watchdog on cycles with no accepted transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 60000) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == {REG_MAX_DIM, 2'b00}) max_dim_m = data[14:0];
	endtask

	// wait until every expected transaction has arrived and the search is quiet
	task automatic drain();
		while (rect_q.size() != 0) @(posedge clk);
		repeat (6000) @(posedge clk);
	endtask

	// offer one request; head returns its first expected rectangle
	task automatic send(input logic [14:0] base, input logic [4:0] wanted, output rect_t head);
		int n0;
		in_valid <= 1; base_resolution <= base; wanted_maps <= wanted;
		n0 = rect_q.size();
		predict_layout(base, wanted);
		head = rect_q[n0];
		do @(posedge clk); while (!in_ready);
	endtask

	// send random requests in bursts, with random gaps between some of the bursts
	task automatic random_traffic(input int count);
		int burst;
		logic [14:0] b;
		rect_t head;
		while (count > 0) begin
			burst = $urandom_range(1, 6);
			for (int i = 0; i < burst && count > 0; i++, count--) begin
				case ($urandom_range(0, 3))
					0: b = 15'($urandom_range(0, 300));
					1: b = 15'($urandom_range(256, 2048));
					2: b = 15'($urandom);
					default: b = 15'($urandom_range(0, 16384));
				endcase
				send(b, 5'($urandom_range(0, 31)), head);
			end
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		in_valid <= 0;
	endtask

	row_t dir[$];

	initial begin
		rect_t head;
		errors = 0; idle_cycles = 0; hold_off = 0; max_dim_m = MAX_DIM_RST;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; base_resolution = 0; wanted_maps = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: base, wanted, known result fields where obvious
		dir = '{
			'{15'd0, 5'd0, 1, 15'd256, 15'd384, 5'd0},
			'{15'd256, 5'd1, 0, 0, 0, 0},
			'{15'd100, 5'd16, 0, 0, 0, 0},
			'{15'd300, 5'd31, 0, 0, 0, 0},
			'{15'd16384, 5'd0, 1, 15'd16384, 15'd16384, 5'd0},
			'{15'd16384, 5'd1, 0, 0, 0, 0},
			'{15'h7fff, 5'd3, 0, 0, 0, 0},
			'{15'd8192, 5'd2, 0, 0, 0, 0},
			'{15'd4096, 5'd17, 0, 0, 0, 0},
			'{15'd1024, 5'd5, 0, 0, 0, 0},
			'{15'd257, 5'd15, 0, 0, 0, 0},
			'{15'd5555, 5'd10, 0, 0, 0, 0}
		};
		foreach (dir[i]) begin
			send(dir[i].base, dir[i].wanted, head);
			if (dir[i].known && (head.aw !== dir[i].exp_aw ||
					head.ah !== dir[i].exp_ah || head.placed !== dir[i].exp_placed)) begin
				$error("directed row %0d table disagrees with predictor", i);
				errors++;
			end
		end
		in_valid <= 0;
		drain();

		// small limits and zero, including nothing fitting
		apb_write({REG_MAX_DIM, 2'b00}, 32'd0);
		send(15'd256, 5'd4, head);
		in_valid <= 0;
		drain();
		apb_write({REG_MAX_DIM, 2'b00}, 32'd1000);
		hold_off = 1;
		random_traffic(30);
		drain();
		apb_write({REG_MAX_DIM, 2'b00}, 32'h7fff);
		random_traffic(25);
		drain();
		apb_write({REG_MAX_DIM, 2'b00}, 32'd4096);
		random_traffic(25);
		drain();
		apb_write({REG_MAX_DIM, 2'b00}, 32'd16384);
		random_traffic(25);
		while (rect_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule
